>>> hw/rtl/e2rm_pkg.sv
// Shared types, constants and helper functions of the Euler-angle rotation block.
`timescale 1ns / 1ps
`default_nettype none

package e2rm_pkg;

   // Default configuration of the block.
   localparam int ANGLE_BITS_DEF     = 16;
   localparam int COEF_FRAC_BITS_DEF = 14;

   // Fixed width of every field on the request and response channels.
   localparam int FIELD_BITS = 16;

   // Series length and Q30 constants of the sine and cosine evaluation.
   localparam int          TAYLOR_TERMS = 9;
   localparam int          Q30_SHIFT    = 30;
   localparam logic [30:0] HALF_PI_Q30  = 31'd1686629713;
   localparam logic [30:0] Q30_ONE      = 31'h4000_0000;

   // Pipeline depths: two front stages, three per series step and two back
   // stages in each lane, then three stages in the matrix merge.
   localparam int LANE_STAGES  = 3 * TAYLOR_TERMS + 4;
   localparam int MERGE_STAGES = 3;
   localparam int PIPE_STAGES  = LANE_STAGES + MERGE_STAGES;

   // Number of matrix entries in one response.
   localparam int ROT_ENTRIES = 9;

   // Signed Q30 sine or cosine, and an exact signed Q60 product or sum.
   typedef logic signed [31:0] trig_type;
   typedef logic signed [63:0] q60_type;

   typedef struct packed {
      trig_type sin_v;
      trig_type cos_v;
   } sincos_type;

   // Divisor of series step k of the sine.
   function automatic int unsigned sin_div(input int unsigned k);
      return (2 * k) * (2 * k + 1);
   endfunction

   // Divisor of series step k of the cosine.
   function automatic int unsigned cos_div(input int unsigned k);
      return (2 * k - 1) * (2 * k);
   endfunction

   // Shift right by sh with rounding to nearest, ties away from zero.
   function automatic q60_type round_away(input q60_type v, input int unsigned sh);
      logic [63:0] mag;
      logic [63:0] half;
      half = 64'd1 << (sh - 1);
      mag  = v[63] ? 64'(-v) : 64'(v);
      mag  = (mag + half) >> sh;
      return v[63] ? -q60_type'(mag) : q60_type'(mag);
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/e2rm_req_if.sv
// Request channel: three binary angles with a valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none

interface e2rm_req_if import e2rm_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [FIELD_BITS-1:0] angle_theta;
   logic [FIELD_BITS-1:0] angle_alpha;
   logic [FIELD_BITS-1:0] angle_phi;

   modport source (output valid, output angle_theta, output angle_alpha,
                   output angle_phi, input ready);
   modport sink   (input valid, input angle_theta, input angle_alpha,
                   input angle_phi, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/e2rm_rsp_if.sv
// Response channel: nine rotation matrix entries with a valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none

interface e2rm_rsp_if import e2rm_pkg::*;;
   logic                         valid;
   logic                         ready;
   logic signed [FIELD_BITS-1:0] rot_00;
   logic signed [FIELD_BITS-1:0] rot_01;
   logic signed [FIELD_BITS-1:0] rot_02;
   logic signed [FIELD_BITS-1:0] rot_10;
   logic signed [FIELD_BITS-1:0] rot_11;
   logic signed [FIELD_BITS-1:0] rot_12;
   logic signed [FIELD_BITS-1:0] rot_20;
   logic signed [FIELD_BITS-1:0] rot_21;
   logic signed [FIELD_BITS-1:0] rot_22;

   modport source (output valid, output rot_00, output rot_01, output rot_02,
                   output rot_10, output rot_11, output rot_12, output rot_20,
                   output rot_21, output rot_22, input ready);
   modport sink   (input valid, input rot_00, input rot_01, input rot_02,
                   input rot_10, input rot_11, input rot_12, input rot_20,
                   input rot_21, input rot_22, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/e2rm_sincos_lane.sv
// One angle lane: pipelined Taylor-series sine and cosine in signed Q30.
`timescale 1ns / 1ps
`default_nettype none

module e2rm_sincos_lane import e2rm_pkg::*; #(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  advance,
   input  logic [FIELD_BITS-1:0] angle,
   output sincos_type            result
);

   localparam int REM_BITS  = ANGLE_BITS - 2;
   localparam int XPROD_BITS = REM_BITS + 31;

   typedef enum logic [1:0] {
      QUAD_I   = 2'd0,
      QUAD_II  = 2'd1,
      QUAD_III = 2'd2,
      QUAD_IV  = 2'd3
   } quad_type;

   // Values that ride along with the series steps.
   typedef struct packed {
      logic [30:0] x;
      logic [31:0] x2;
      quad_type    quad;
   } carry_type;

   // Front stage: map the angle within its quadrant to Q30 radians.
   logic [ANGLE_BITS-1:0] ang;
   logic [REM_BITS-1:0]   rem;
   logic [XPROD_BITS-1:0] x_prod;
   logic [30:0]           x_in;
   logic [30:0]           x_ff;
   quad_type              quad_ff;

   // Only the low ANGLE_BITS bits of the field form the angle.
   assign ang    = ANGLE_BITS'(angle);
   assign rem    = ang[REM_BITS-1:0];
   assign x_prod = XPROD_BITS'(rem) * XPROD_BITS'(HALF_PI_Q30)
                   + (XPROD_BITS'(1) << (REM_BITS - 1));
   assign x_in   = 31'(x_prod >> REM_BITS);

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff    <= x_in;
         quad_ff <= quad_type'(ang[ANGLE_BITS-1 -: 2]);
      end
   end

   // Second stage: square of the reduced angle in Q30.
   logic [61:0] x2_prod;
   carry_type   carry_ff;

   assign x2_prod = 62'(x_ff) * 62'(x_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         carry_ff.x    <= x_ff;
         carry_ff.x2   <= 32'(x2_prod >> Q30_SHIFT);
         carry_ff.quad <= quad_ff;
      end
   end

   // Horner chain, highest series term first.
   logic [30:0] t_sin [TAYLOR_TERMS+1];
   logic [30:0] t_cos [TAYLOR_TERMS+1];
   carry_type   carry [TAYLOR_TERMS+1];

   assign t_sin[0] = Q30_ONE;
   assign t_cos[0] = Q30_ONE;
   assign carry[0] = carry_ff;

   for (genvar j = 0; j < TAYLOR_TERMS; j++) begin : g_step
      localparam int unsigned K      = TAYLOR_TERMS - j;
      localparam int unsigned DIV_S  = sin_div(K);
      localparam int unsigned DIV_C  = cos_div(K);
      localparam logic [31:0] RECIP_S = 32'(64'd4294967296 / 64'(DIV_S));
      localparam logic [31:0] RECIP_C = 32'(64'd4294967296 / 64'(DIV_C));

      logic [62:0] prod_s_ff, prod_c_ff;
      carry_type   carry_a_ff, carry_b_ff, carry_c_ff;
      logic [31:0] num_s, num_c;
      logic [63:0] est_s, est_c;
      logic [31:0] num_s_ff, num_c_ff, quo_s_ff, quo_c_ff;
      logic [31:0] rem_s, rem_c, quo_s, quo_c;
      logic [30:0] term_s_ff, term_c_ff;

      // Product of the square and the running term.
      always_ff @(posedge clock) begin
         if (advance) begin
            prod_s_ff  <= 63'(carry[j].x2) * 63'(t_sin[j]);
            prod_c_ff  <= 63'(carry[j].x2) * 63'(t_cos[j]);
            carry_a_ff <= carry[j];
         end
      end

      // Quotient estimate by the reciprocal of the step divisor.
      assign num_s = 32'(prod_s_ff >> Q30_SHIFT);
      assign num_c = 32'(prod_c_ff >> Q30_SHIFT);
      assign est_s = 64'(num_s) * 64'(RECIP_S);
      assign est_c = 64'(num_c) * 64'(RECIP_C);

      always_ff @(posedge clock) begin
         if (advance) begin
            num_s_ff   <= num_s;
            num_c_ff   <= num_c;
            quo_s_ff   <= 32'(est_s >> 32);
            quo_c_ff   <= 32'(est_c >> 32);
            carry_b_ff <= carry_a_ff;
         end
      end

      // The estimate is at most one low; fix it and form the next term.
      assign rem_s = num_s_ff - 32'(quo_s_ff * 32'(DIV_S));
      assign rem_c = num_c_ff - 32'(quo_c_ff * 32'(DIV_C));
      assign quo_s = (rem_s >= 32'(DIV_S)) ? quo_s_ff + 32'd1 : quo_s_ff;
      assign quo_c = (rem_c >= 32'(DIV_C)) ? quo_c_ff + 32'd1 : quo_c_ff;

      always_ff @(posedge clock) begin
         if (advance) begin
            term_s_ff  <= 31'(32'(Q30_ONE) - quo_s);
            term_c_ff  <= 31'(32'(Q30_ONE) - quo_c);
            carry_c_ff <= carry_b_ff;
         end
      end

      assign t_sin[j+1] = term_s_ff;
      assign t_cos[j+1] = term_c_ff;
      assign carry[j+1] = carry_c_ff;
   end

   // Sine of the reduced angle is x times the series, rounded to Q30.
   logic [61:0] sin_prod;
   logic [30:0] sin_q_ff, cos_q_ff;
   quad_type    quad_end_ff;

   assign sin_prod = 62'(carry[TAYLOR_TERMS].x) * 62'(t_sin[TAYLOR_TERMS])
                     + (62'd1 << (Q30_SHIFT - 1));

   always_ff @(posedge clock) begin
      if (advance) begin
         sin_q_ff    <= 31'(sin_prod >> Q30_SHIFT);
         cos_q_ff    <= t_cos[TAYLOR_TERMS];
         quad_end_ff <= carry[TAYLOR_TERMS].quad;
      end
   end

   // Quadrant symmetry gives the full-turn sine and cosine.
   trig_type   s_pos, c_pos;
   sincos_type result_in, result_ff;

   assign s_pos = trig_type'({1'b0, sin_q_ff});
   assign c_pos = trig_type'({1'b0, cos_q_ff});

   always_comb begin
      case (quad_end_ff)
         QUAD_I: begin
            result_in.sin_v = s_pos;
            result_in.cos_v = c_pos;
         end
         QUAD_II: begin
            result_in.sin_v = c_pos;
            result_in.cos_v = -s_pos;
         end
         QUAD_III: begin
            result_in.sin_v = -s_pos;
            result_in.cos_v = -c_pos;
         end
         default: begin
            result_in.sin_v = -c_pos;
            result_in.cos_v = s_pos;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

>>> hw/rtl/e2rm_merge.sv
// Merge stage: combines the three lanes' sines and cosines into the matrix.
`timescale 1ns / 1ps
`default_nettype none

module e2rm_merge import e2rm_pkg::*; #(
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  advance,
   input  sincos_type            theta,
   input  sincos_type            alpha,
   input  sincos_type            phi,
   output logic [FIELD_BITS-1:0] rot [ROT_ENTRIES]
);

   localparam int unsigned FINAL_SHIFT = 2 * Q30_SHIFT - COEF_FRAC_BITS;
   localparam q60_type     LIMIT       = q60_type'(64'd1 << COEF_FRAC_BITS);

   trig_type st, ct, sa, ca, sp, cp;

   assign st = theta.sin_v;
   assign ct = theta.cos_v;
   assign sa = alpha.sin_v;
   assign ca = alpha.cos_v;
   assign sp = phi.sin_v;
   assign cp = phi.cos_v;

   // First stage: all two-factor products, exact in Q60.
   q60_type  cact_ff, cast_ff, cpst_ff, cpct_ff, casp_ff, spst_ff, ctsp_ff, cacp_ff;
   q60_type  ctsa_ff, sasp_ff, cpsa_ff;
   trig_type st_ff, sa_ff, sp_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         cact_ff <= q60_type'(ca) * q60_type'(ct);
         cast_ff <= q60_type'(ca) * q60_type'(st);
         cpst_ff <= q60_type'(cp) * q60_type'(st);
         cpct_ff <= q60_type'(cp) * q60_type'(ct);
         casp_ff <= q60_type'(ca) * q60_type'(sp);
         spst_ff <= q60_type'(sp) * q60_type'(st);
         ctsp_ff <= q60_type'(ct) * q60_type'(sp);
         cacp_ff <= q60_type'(ca) * q60_type'(cp);
         ctsa_ff <= q60_type'(ct) * q60_type'(sa);
         sasp_ff <= q60_type'(sa) * q60_type'(sp);
         cpsa_ff <= q60_type'(cp) * q60_type'(sa);
         st_ff   <= st;
         sa_ff   <= sa;
         sp_ff   <= sp;
      end
   end

   // Second stage: three-factor products from a leading pair rounded to Q30.
   trig_type lead_ctsa, lead_sasp, lead_cpct, lead_cpsa;
   q60_type  tri_0_ff, tri_1_ff, tri_2_ff, tri_3_ff, sa_q60_ff;
   q60_type  cact_b_ff, cast_b_ff, cpst_b_ff, cpct_b_ff, casp_b_ff;
   q60_type  spst_b_ff, ctsp_b_ff, cacp_b_ff;

   assign lead_ctsa = trig_type'(round_away(ctsa_ff, Q30_SHIFT));
   assign lead_sasp = trig_type'(round_away(sasp_ff, Q30_SHIFT));
   assign lead_cpct = trig_type'(round_away(cpct_ff, Q30_SHIFT));
   assign lead_cpsa = trig_type'(round_away(cpsa_ff, Q30_SHIFT));

   always_ff @(posedge clock) begin
      if (advance) begin
         tri_0_ff  <= q60_type'(lead_ctsa) * q60_type'(sp_ff);
         tri_1_ff  <= q60_type'(lead_sasp) * q60_type'(st_ff);
         tri_2_ff  <= q60_type'(lead_cpct) * q60_type'(sa_ff);
         tri_3_ff  <= q60_type'(lead_cpsa) * q60_type'(st_ff);
         sa_q60_ff <= q60_type'(sa_ff) <<< Q30_SHIFT;
         cact_b_ff <= cact_ff;
         cast_b_ff <= cast_ff;
         cpst_b_ff <= cpst_ff;
         cpct_b_ff <= cpct_ff;
         casp_b_ff <= casp_ff;
         spst_b_ff <= spst_ff;
         ctsp_b_ff <= ctsp_ff;
         cacp_b_ff <= cacp_ff;
      end
   end

   // Third stage: the nine entries as exact Q60 sums.
   q60_type entry_ff [ROT_ENTRIES];

   always_ff @(posedge clock) begin
      if (advance) begin
         entry_ff[0] <= cact_b_ff;
         entry_ff[1] <= -cast_b_ff;
         entry_ff[2] <= sa_q60_ff;
         entry_ff[3] <= tri_0_ff + cpst_b_ff;
         entry_ff[4] <= cpct_b_ff - tri_1_ff;
         entry_ff[5] <= -casp_b_ff;
         entry_ff[6] <= spst_b_ff - tri_2_ff;
         entry_ff[7] <= tri_3_ff + ctsp_b_ff;
         entry_ff[8] <= cacp_b_ff;
      end
   end

   // Round to the coefficient format and saturate to plus or minus one.
   for (genvar i = 0; i < ROT_ENTRIES; i++) begin : g_finish
      q60_type rounded;
      q60_type clamped;

      assign rounded = round_away(entry_ff[i], FINAL_SHIFT);
      assign clamped = (rounded > LIMIT)  ? LIMIT  :
                       (rounded < -LIMIT) ? -LIMIT : rounded;
      assign rot[i]  = clamped[FIELD_BITS-1:0];
   end

endmodule

`default_nettype wire

>>> hw/rtl/euler_angles_to_rotation_matrix.sv
// Throughput: one request per cycle unless the pipeline halts; three sine/cosine
// lanes and the merge stage are fully pipelined, one register stage per multiply.
// The pipeline halts only when its last stage holds a result and the output
// register still holds one that has not been taken.
// Reset clears the stage valid bits and the output valid; data is not reset.
`timescale 1ns / 1ps
`default_nettype none

module euler_angles_to_rotation_matrix import e2rm_pkg::*; #(
   parameter int ANGLE_BITS     = ANGLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   e2rm_req_if.sink          req_chan,
   e2rm_rsp_if.source        rsp_chan
);

   localparam int LAST = PIPE_STAGES - 1;

   logic                   advance;
   logic [PIPE_STAGES-1:0] valid_ff, valid_in;
   logic                   out_valid_ff, out_valid_in;

   // The pipeline moves unless a finished result is blocked behind the output.
   assign advance = !(valid_ff[LAST] && out_valid_ff && !rsp_chan.ready);
   assign req_chan.ready = advance;

   // Valid bits travel with the data.
   assign valid_in     = advance ? {valid_ff[LAST-1:0], req_chan.valid} : valid_ff;
   assign out_valid_in = (advance && valid_ff[LAST]) || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // One lane per angle.
   sincos_type sc_theta, sc_alpha, sc_phi;

   e2rm_sincos_lane #(.ANGLE_BITS(ANGLE_BITS)) u_lane_theta (
      .clock   (clock),
      .advance (advance),
      .angle   (req_chan.angle_theta),
      .result  (sc_theta)
   );

   e2rm_sincos_lane #(.ANGLE_BITS(ANGLE_BITS)) u_lane_alpha (
      .clock   (clock),
      .advance (advance),
      .angle   (req_chan.angle_alpha),
      .result  (sc_alpha)
   );

   e2rm_sincos_lane #(.ANGLE_BITS(ANGLE_BITS)) u_lane_phi (
      .clock   (clock),
      .advance (advance),
      .angle   (req_chan.angle_phi),
      .result  (sc_phi)
   );

   // Matrix merge.
   logic [FIELD_BITS-1:0] rot [ROT_ENTRIES];

   e2rm_merge #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_merge (
      .clock   (clock),
      .advance (advance),
      .theta   (sc_theta),
      .alpha   (sc_alpha),
      .phi     (sc_phi),
      .rot     (rot)
   );

   // Output register, loaded when the last stage hands over a result.
   logic [FIELD_BITS-1:0] rot_ff [ROT_ENTRIES];

   always_ff @(posedge clock) begin
      if (advance && valid_ff[LAST]) begin
         rot_ff <= rot;
      end
   end

   assign rsp_chan.valid  = out_valid_ff;
   assign rsp_chan.rot_00 = rot_ff[0];
   assign rsp_chan.rot_01 = rot_ff[1];
   assign rsp_chan.rot_02 = rot_ff[2];
   assign rsp_chan.rot_10 = rot_ff[3];
   assign rsp_chan.rot_11 = rot_ff[4];
   assign rsp_chan.rot_12 = rot_ff[5];
   assign rsp_chan.rot_20 = rot_ff[6];
   assign rsp_chan.rot_21 = rot_ff[7];
   assign rsp_chan.rot_22 = rot_ff[8];

`ifndef SYNTHESIS
   // No response may be pending right after reset.
   assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("response valid after reset");

   // A taken response with nothing behind it leaves the output empty.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !valid_ff[LAST]) |=> !rsp_chan.valid)
      else $error("response appeared without a finished result");

   // A stalled pipeline must be holding a result it cannot hand over.
   assert property (@(posedge clock) disable iff (reset)
      (!req_chan.ready) |=> (rsp_chan.valid || valid_ff[LAST]))
      else $error("pipeline stalled with free output");

   // Entries rot_00 and rot_11 stay within plus or minus one in the coefficient format.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (COEF_FRAC_BITS < FIELD_BITS - 1)) |->
      ((rsp_chan.rot_00 <= (1 <<< COEF_FRAC_BITS)) &&
       (rsp_chan.rot_00 >= -(1 <<< COEF_FRAC_BITS)) &&
       (rsp_chan.rot_11 <= (1 <<< COEF_FRAC_BITS)) &&
       (rsp_chan.rot_11 >= -(1 <<< COEF_FRAC_BITS))))
      else $error("matrix entry outside saturation range");
`endif

endmodule

`default_nettype wire

>>> tb/tb_euler_angles_to_rotation_matrix.sv
// Self-checking testbench of the Euler-angle rotation matrix block.
`timescale 1ns / 1ps
`default_nettype none

module tb_euler_angles_to_rotation_matrix;
   import e2rm_pkg::*;

   typedef logic [ROT_ENTRIES-1:0][FIELD_BITS-1:0] rot_matrix_type;

   typedef struct {
      logic [FIELD_BITS-1:0] theta;
      logic [FIELD_BITS-1:0] alpha;
      logic [FIELD_BITS-1:0] phi;
      bit                    drain_first;
   } pose_request_type;

   logic clock;
   logic reset;

   e2rm_req_if req_bus ();
   e2rm_rsp_if rsp_bus ();

   euler_angles_to_rotation_matrix DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   pose_request_type pose_requests[$];
   rot_matrix_type   matrices_expected[$];
   int               fail_count = 0;
   int               cycle_count = 0;
   int               hold_left = 0;
   bit               calm;

   // Clock with an 8 ns period.
   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // A stretch of the run with no idling on either side.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end
   assign calm = (cycle_count >= 1000) && (cycle_count < 1400);

   // Shift right with rounding to nearest, ties away from zero.
   function automatic longint shift_round(input longint v, input int sh);
      longint mag;
      mag = (v < 0) ? -v : v;
      mag = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
      return (v < 0) ? -mag : mag;
   endfunction

   // Q30 sine and cosine of a 16-bit binary angle by Taylor series and quadrant symmetry.
   function automatic void angle_sin_cos(input logic [FIELD_BITS-1:0] ang,
                                         output longint s_out, output longint c_out);
      logic [1:0] quad;
      longint     rem, x, x2, ts, tc, s;
      quad = ang[15:14];
      rem  = longint'(ang[13:0]);
      x    = (rem * longint'(HALF_PI_Q30) + (64'sd1 <<< 13)) >>> 14;
      x2   = (x * x) >>> 30;
      ts   = 64'sd1 <<< 30;
      tc   = 64'sd1 <<< 30;
      for (int k = TAYLOR_TERMS; k >= 1; k--) begin
         ts = (64'sd1 <<< 30) - (x2 * ts) / (longint'((2 * k) * (2 * k + 1)) <<< 30);
         tc = (64'sd1 <<< 30) - (x2 * tc) / (longint'((2 * k - 1) * (2 * k)) <<< 30);
      end
      s = shift_round(x * ts, 30);
      case (quad)
         2'd0: begin s_out = s;   c_out = tc;  end
         2'd1: begin s_out = tc;  c_out = -s;  end
         2'd2: begin s_out = -s;  c_out = -tc; end
         default: begin s_out = -tc; c_out = s; end
      endcase
   endfunction

   // Round a Q60 value to Q1.14 and saturate to plus or minus one.
   function automatic logic [FIELD_BITS-1:0] q60_to_entry(input longint q60);
      longint v;
      v = shift_round(q60, 60 - COEF_FRAC_BITS_DEF);
      if (v > 16384) v = 16384;
      if (v < -16384) v = -16384;
      return v[FIELD_BITS-1:0];
   endfunction

   // Three-factor product: leading pair rounded to Q30, then exact.
   function automatic longint triple_product(input longint a, input longint b, input longint c);
      return shift_round(a * b, 30) * c;
   endfunction

   // Nine matrix entries of one pose.
   function automatic rot_matrix_type rotation_of(input pose_request_type p);
      longint         st, ct, sa, ca, sp, cp;
      rot_matrix_type m;
      angle_sin_cos(p.theta, st, ct);
      angle_sin_cos(p.alpha, sa, ca);
      angle_sin_cos(p.phi, sp, cp);
      m[0] = q60_to_entry(ca * ct);
      m[1] = q60_to_entry(-(ca * st));
      m[2] = q60_to_entry(sa <<< 30);
      m[3] = q60_to_entry(triple_product(ct, sa, sp) + cp * st);
      m[4] = q60_to_entry(-triple_product(sa, sp, st) + cp * ct);
      m[5] = q60_to_entry(-(ca * sp));
      m[6] = q60_to_entry(-triple_product(cp, ct, sa) + sp * st);
      m[7] = q60_to_entry(triple_product(cp, sa, st) + ct * sp);
      m[8] = q60_to_entry(ca * cp);
      return m;
   endfunction

   // Request driver: predicts each accepted request and loads the next one.
   always @(posedge clock) begin : drive_requests
      int               outstanding;
      bit               go;
      pose_request_type nxt;
      pose_request_type cur;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         outstanding = matrices_expected.size();
         if (req_bus.valid && req_bus.ready) begin
            cur.theta = req_bus.angle_theta;
            cur.alpha = req_bus.angle_alpha;
            cur.phi   = req_bus.angle_phi;
            matrices_expected.push_back(rotation_of(cur));
            outstanding++;
         end
         if (!(req_bus.valid && !req_bus.ready)) begin
            go = (pose_requests.size() > 0) && (calm || $urandom_range(99) >= 22);
            if (go && pose_requests[0].drain_first && outstanding != 0) go = 1'b0;
            if (go) begin
               nxt = pose_requests.pop_front();
               req_bus.valid       <= 1'b1;
               req_bus.angle_theta <= nxt.theta;
               req_bus.angle_alpha <= nxt.alpha;
               req_bus.angle_phi   <= nxt.phi;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Response side: random stalls plus one long hold-off that backs up the pipeline.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (cycle_count == 600) begin
            hold_left <= 150;
            rsp_bus.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= calm || ($urandom_range(99) >= 22);
         end
      end
   end

   // Response checker: compares each matrix entry with the oldest expectation.
   always @(posedge clock) begin : check_responses
      rot_matrix_type got;
      rot_matrix_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = {rsp_bus.rot_22, rsp_bus.rot_21, rsp_bus.rot_20, rsp_bus.rot_12,
                rsp_bus.rot_11, rsp_bus.rot_10, rsp_bus.rot_02, rsp_bus.rot_01,
                rsp_bus.rot_00};
         if (matrices_expected.size() == 0) begin
            $display("%0t: unexpected response", $time);
            fail_count++;
         end else begin
            want = matrices_expected.pop_front();
            for (int i = 0; i < ROT_ENTRIES; i++) begin
               if (got[i] !== want[i]) begin
                  $display("%0t: rot_%0d%0d expected %0d actual %0d", $time, i / 3, i % 3,
                           $signed(want[i]), $signed(got[i]));
                  fail_count++;
               end
            end
         end
      end
   end

   // Stimulus: directed poses, then random poses with a few drain points.
   initial begin : stimulus
      logic [FIELD_BITS-1:0] corner[10];
      pose_request_type p;
      corner = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF,
                 16'h0001, 16'h3FFF, 16'h2000, 16'h7FFF, 16'hBFFF};
      req_bus.valid       = 1'b0;
      req_bus.angle_theta = '0;
      req_bus.angle_alpha = '0;
      req_bus.angle_phi   = '0;
      rsp_bus.ready       = 1'b0;
      reset = 1'b1;
      for (int i = 0; i < 24; i++) begin
         p.theta = corner[i % 10];
         p.alpha = corner[(i * 3 + 1) % 10];
         p.phi   = corner[(i * 7 + 2) % 10];
         p.drain_first = 1'b0;
         pose_requests.push_back(p);
      end
      for (int i = 0; i < 1450; i++) begin
         p.theta = 16'($urandom_range(16'hFFFF));
         p.alpha = 16'($urandom_range(16'hFFFF));
         p.phi   = 16'($urandom_range(16'hFFFF));
         p.drain_first = (i % 400 == 399);
         pose_requests.push_back(p);
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      while (pose_requests.size() != 0 || req_bus.valid || matrices_expected.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
